@@ design/time_weighted_mean_and_std_assert.svh @@
// Assertion macros for the time-weighted mean and std block
`ifndef TIME_WEIGHTED_MEAN_AND_STD_ASSERT_SVH
`define TIME_WEIGHTED_MEAN_AND_STD_ASSERT_SVH
`ifndef ASSERT_OFF
`define TWMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWMS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TWMS_ASSERT(lbl, prop, msg)
`define TWMS_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/twms_pkg.sv @@
// Shared constants and helpers for the time-weighted mean and std block
package twms_pkg;
    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int TIME_W     = 63;
    localparam int PRICE_W    = 40;
    localparam int WIN_W      = 40;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 80;
    localparam int ACC_W      = 128;
    localparam int PROD_W     = 144;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 40'd30000000000;
    localparam logic [PRICE_W-1:0] PRICE_MAX    = '1;
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction
endpackage

@@ design/time_weighted_mean_and_std.sv @@
// Time-weighted mean and std of a price over a sliding window, ring kept in one memory
// Tick: a write, then a read and check per entry while pruning. Query on N entries: per entry
// a memory read and a 40x32 multiplier run over 4 partial products, twice for the
// deviation pass; then a bit-serial divide per pass and a bit-serial square root.
// One item at a time; a result waits in the output register while the next item is taken.
// Reset clears count, oldest slot, overflow flag, sets the window to 30e9 ns; ring undefined.
module time_weighted_mean_and_std (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] cfg_data,     // window_ns
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [twms_pkg::IN_DATA_W-1:0] s_tdata,  // timestamp[62:0], price[102:63]
    input  logic [0:0]  s_tuser,      // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [twms_pkg::OUT_DATA_W-1:0] m_tdata, // mean_price[39:0], std_price[79:40]
    output logic [1:0]  m_tuser       // window_empty[0], overflowed[1]
);
    import twms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TICK_WR, S_PRUNE_RD, S_PRUNE_CHK, S_QSTART, S_WALK_RD0, S_WALK_LD0,
        S_WALK_NX, S_WALK_EN, S_SPAN, S_MUL_P, S_MUL_A, S_ACC, S_ADVANCE, S_DIV,
        S_DIV_DONE, S_SQRT, S_OUT
    } state_t;

    localparam int WORD_W = TIME_W + PRICE_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    state_t              state_reg;
    logic [WIN_W-1:0]    window_reg;
    logic [WIN_W-1:0]    w_reg;
    logic signed [63:0]  ws_reg;
    logic [TIME_W-1:0]   ts_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [ADDR_W-1:0]   oldest_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [TIME_W-1:0]   cur_time_reg;
    logic [PRICE_W-1:0]  cur_price_reg;
    logic [TIME_W-1:0]   en_reg;
    logic [PRICE_W-1:0]  nxt_price_reg;
    logic [63:0]         dur_reg;
    logic                pass_reg;
    logic                sq_done_reg;
    logic [79:0]         mx_reg;
    logic [63:0]         my_reg;
    logic [1:0]          k_reg;
    logic [71:0]         pp_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    num_reg;
    logic [39:0]         rem_reg;
    logic [6:0]          cnt_reg;
    logic [79:0]         rad_reg;
    logic [42:0]         srem_reg;
    logic [PRICE_W-1:0]  root_reg;
    logic [PRICE_W-1:0]  mean_reg;
    logic                empty_reg;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                full;
    logic [ADDR_W-1:0]   base_oldest;
    logic [CNT_W-1:0]    base_count;
    logic [TIME_W-1:0]   rd_time;
    logic [PRICE_W-1:0]  rd_price;
    logic signed [63:0]  st_c;
    logic [TIME_W-1:0]   en_c;
    logic signed [63:0]  en_s;
    logic                live_c;
    logic [63:0]         dur_c;
    logic [PRICE_W-1:0]  d_c;
    logic [39:0]         xch;
    logic [31:0]         ych;
    logic [71:0]         pp_c;
    logic [7:0]          sh_c;
    logic [ACC_W-1:0]    addend_c;
    logic [ACC_W:0]      sum_c;
    logic [40:0]         dtrial;
    logic                dge;
    logic [40:0]         ddiff;
    logic [42:0]         sr2;
    logic [42:0]         strial;
    logic [WIN_W-1:0]    weff;
    logic                s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign rd_time  = rd_data_reg[WORD_W-1:PRICE_W];
    assign rd_price = rd_data_reg[PRICE_W-1:0];
    assign weff     = (window_reg == '0) ? WIN_W'(1) : window_reg;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign base_oldest = full ? slot_add(oldest_reg, CNT_W'(1)) : oldest_reg;
    assign base_count  = full ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        mem_we    = (state_reg == S_TICK_WR);
        mem_waddr = slot_add(base_oldest, base_count);
        mem_re    = 1'b0;
        mem_raddr = oldest_reg;
        case (state_reg)
            S_PRUNE_RD, S_WALK_RD0:
            begin
                mem_re = 1'b1;
            end
            S_WALK_NX:
            begin
                mem_re    = (idx_reg < count_reg);
                mem_raddr = slot_add(oldest_reg, idx_reg);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {ts_reg, price_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // span clipping and deviation
    always_comb
    begin
        st_c   = ($signed({1'b0, cur_time_reg}) < ws_reg) ? ws_reg : $signed({1'b0, cur_time_reg});
        en_c   = (en_reg > ts_reg) ? ts_reg : en_reg;
        en_s   = $signed({1'b0, en_c});
        live_c = (en_s > st_c);
        dur_c  = 64'(en_s - st_c);
        d_c    = (cur_price_reg >= mean_reg) ? cur_price_reg - mean_reg
                                             : mean_reg - cur_price_reg;
    end

    // partial products, saturating accumulate, and divide and square-root trial steps
    always_comb
    begin
        xch  = k_reg[1] ? mx_reg[79:40] : mx_reg[39:0];
        ych  = k_reg[0] ? my_reg[63:32] : my_reg[31:0];
        pp_c = 72'(xch) * 72'(ych);
        case (k_reg)
            2'd0:    sh_c = 8'd0;
            2'd1:    sh_c = 8'd32;
            2'd2:    sh_c = 8'd40;
            default: sh_c = 8'd72;
        endcase
        addend_c = (pass_reg && (prod_reg[PROD_W-1:ACC_W] != '0)) ? '1 : prod_reg[ACC_W-1:0];
        sum_c    = {1'b0, acc_reg} + {1'b0, addend_c};
        dtrial   = {rem_reg, num_reg[ACC_W-1]};
        dge      = (dtrial >= {1'b0, w_reg});
        ddiff    = dtrial - {1'b0, w_reg};
        sr2      = {srem_reg[40:0], rad_reg[79:78]};
        strial   = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            window_reg   <= WINDOW_RESET;
            oldest_reg   <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        ts_reg    <= s_tdata[TIME_W-1:0];
                        price_reg <= s_tdata[TIME_W+PRICE_W-1:TIME_W];
                        w_reg     <= weff;
                        ws_reg    <= $signed({1'b0, s_tdata[TIME_W-1:0]} - {24'd0, weff});
                        state_reg <= (s_tuser[0] == KIND_TICK) ? S_TICK_WR : S_QSTART;
                    end
                end
                S_TICK_WR:
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    oldest_reg <= base_oldest;
                    count_reg  <= base_count + CNT_W'(1);
                    state_reg  <= S_PRUNE_RD;
                end
                S_PRUNE_RD:
                begin
                    state_reg <= S_PRUNE_CHK;
                end
                S_PRUNE_CHK:
                begin
                    if ((count_reg != '0) && ($signed({1'b0, rd_time}) < ws_reg))
                    begin
                        oldest_reg <= slot_add(oldest_reg, CNT_W'(1));
                        count_reg  <= count_reg - CNT_W'(1);
                        state_reg  <= S_PRUNE_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_QSTART:
                begin
                    pass_reg <= 1'b0;
                    acc_reg  <= '0;
                    if (count_reg == '0)
                    begin
                        mean_reg  <= '0;
                        root_reg  <= '0;
                        empty_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        empty_reg <= 1'b0;
                        state_reg <= S_WALK_RD0;
                    end
                end
                S_WALK_RD0:
                begin
                    state_reg <= S_WALK_LD0;
                end
                S_WALK_LD0:
                begin
                    cur_time_reg  <= rd_time;
                    cur_price_reg <= rd_price;
                    idx_reg       <= CNT_W'(1);
                    state_reg     <= S_WALK_NX;
                end
                S_WALK_NX:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_WALK_EN;
                    end
                    else
                    begin
                        en_reg    <= ts_reg;
                        state_reg <= S_SPAN;
                    end
                end
                S_WALK_EN:
                begin
                    en_reg        <= rd_time;
                    nxt_price_reg <= rd_price;
                    state_reg     <= S_SPAN;
                end
                S_SPAN:
                begin
                    if (!live_c)
                    begin
                        state_reg <= S_ADVANCE;
                    end
                    else
                    begin
                        dur_reg  <= dur_c;
                        k_reg    <= '0;
                        prod_reg <= '0;
                        if (!pass_reg)
                        begin
                            mx_reg      <= {40'd0, cur_price_reg};
                            my_reg      <= dur_c;
                            sq_done_reg <= 1'b1;
                        end
                        else
                        begin
                            mx_reg      <= {40'd0, d_c};
                            my_reg      <= {24'd0, d_c};
                            sq_done_reg <= 1'b0;
                        end
                        state_reg <= S_MUL_P;
                    end
                end
                S_MUL_P:
                begin
                    pp_reg    <= pp_c;
                    state_reg <= S_MUL_A;
                end
                S_MUL_A:
                begin
                    prod_reg <= prod_reg + (PROD_W'(pp_reg) << sh_c);
                    k_reg    <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? S_ACC : S_MUL_P;
                end
                S_ACC:
                begin
                    if (!sq_done_reg)
                    begin
                        mx_reg      <= prod_reg[79:0];
                        my_reg      <= dur_reg;
                        prod_reg    <= '0;
                        k_reg       <= '0;
                        sq_done_reg <= 1'b1;
                        state_reg   <= S_MUL_P;
                    end
                    else
                    begin
                        acc_reg   <= sum_c[ACC_W] ? '1 : sum_c[ACC_W-1:0];
                        state_reg <= S_ADVANCE;
                    end
                end
                S_ADVANCE:
                begin
                    if (idx_reg < count_reg)
                    begin
                        cur_time_reg  <= en_reg;
                        cur_price_reg <= nxt_price_reg;
                        idx_reg       <= idx_reg + CNT_W'(1);
                        state_reg     <= S_WALK_NX;
                    end
                    else
                    begin
                        num_reg   <= acc_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg   <= dge ? ddiff[39:0] : dtrial[39:0];
                    num_reg   <= {num_reg[ACC_W-2:0], dge};
                    cnt_reg   <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        state_reg <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE:
                begin
                    if (!pass_reg)
                    begin
                        mean_reg  <= (num_reg[ACC_W-1:PRICE_W] != '0) ? PRICE_MAX
                                                                     : num_reg[PRICE_W-1:0];
                        pass_reg  <= 1'b1;
                        acc_reg   <= '0;
                        state_reg <= S_WALK_RD0;
                    end
                    else if (num_reg[ACC_W-1:80] != '0)
                    begin
                        root_reg  <= PRICE_MAX;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rad_reg   <= num_reg[79:0];
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sr2 >= strial)
                    begin
                        srem_reg <= sr2 - strial;
                        root_reg <= {root_reg[PRICE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= sr2;
                        root_reg <= {root_reg[PRICE_W-2:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[77:0], 2'b00};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd39)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {root_reg, mean_reg};
                        m_tuser_reg  <= {ovf_reg, empty_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "time_weighted_mean_and_std_assert.svh"

    `TWMS_NEVER(a_count_range, count_reg > CNT_W'(DEPTH), "entry count beyond ring depth")
    `TWMS_ASSERT(a_ovf_sticky, ovf_reg |=> ovf_reg, "overflow flag cleared")
    `TWMS_ASSERT(a_empty_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "empty result not zero")
    `TWMS_ASSERT(a_tick_write, (s_acc && (s_tuser[0] == KIND_TICK)) |=> (state_reg == S_TICK_WR), "tick request not written")

endmodule
